// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

  // operation codes carried in the input tuser field
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_RAW  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_PULSE     = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE     = 2'd1;
  localparam logic [1:0] REG_STEP_INTERVAL = 2'd2;

  localparam logic [7:0]  ANGLE_FULL        = 8'd180;
  localparam logic [15:0] TICK_SAT          = 16'hFFFF;
  localparam logic [15:0] MIN_PULSE_RST     = 16'd500;
  localparam logic [15:0] MAX_PULSE_RST     = 16'd2500;
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd5;

  // x/180 = (x>>2)/45; reciprocal of 45 scaled by 2^28, low by at most one
  localparam int         DIV_SHIFT = 28;
  localparam int         DIV_RECIP_I = (1 << DIV_SHIFT) / 45;
  localparam logic [22:0] DIV_RECIP = DIV_RECIP_I[22:0];
  localparam logic [22:0] DIV_BY    = 23'd45;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [15:0] step_interval;
  } cfg_t;

  // one emitting word handed from the ramp stage to the pulse pipeline
  typedef struct packed {
    logic        raw_sel;
    logic [15:0] raw_pulse;
    logic [7:0]  angle;
    logic [15:0] span;
  } item_t;

endpackage

// ===== rtl/ssr_ctrl.sv =====
module ssr_ctrl import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_accept,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_target,
  input  logic [7:0]  in_step,
  input  logic [15:0] in_raw,
  input  cfg_t        cfg,
  output item_t       item,
  output logic        item_valid
);

  logic        v1_r;
  logic [1:0]  op1_r;
  logic [7:0]  tgt1_r;
  logic [7:0]  stp1_r;
  logic [15:0] raw1_r;

  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic [7:0]  goal_r, goal_nxt;
  logic [7:0]  rstep_r, rstep_nxt;

  logic [7:0]  tgt_clamp;
  logic [15:0] elapsed_inc;
  logic [8:0]  up_sum;
  logic [7:0]  down_gap;
  logic        emit;

  assign tgt_clamp   = (tgt1_r > ANGLE_FULL) ? ANGLE_FULL : tgt1_r;
  assign elapsed_inc = (elapsed_r < TICK_SAT) ? elapsed_r + 16'd1 : elapsed_r;
  assign up_sum      = {1'b0, cur_r} + {1'b0, rstep_r};
  assign down_gap    = cur_r - goal_r;

  always_comb begin
    elapsed_nxt = elapsed_r;
    cur_nxt     = cur_r;
    goal_nxt    = goal_r;
    rstep_nxt   = rstep_r;
    emit        = 1'b0;
    case (op1_r)
      OP_MOVE: begin
        goal_nxt  = tgt_clamp;
        rstep_nxt = stp1_r;
      end
      OP_SET: begin
        cur_nxt  = tgt_clamp;
        goal_nxt = tgt_clamp;
        emit     = 1'b1;
      end
      OP_RAW: begin
        emit = 1'b1;
      end
      OP_TICK: begin
        if (elapsed_inc < cfg.step_interval) begin
          elapsed_nxt = elapsed_inc;
        end else begin
          elapsed_nxt = '0;
          emit        = 1'b1;
          if (cur_r < goal_r) begin
            cur_nxt = (up_sum > {1'b0, goal_r}) ? goal_r : up_sum[7:0];
          end else if (cur_r > goal_r) begin
            cur_nxt = (down_gap <= rstep_r) ? goal_r : cur_r - rstep_r;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      elapsed_r <= '0;
      cur_r     <= '0;
      goal_r    <= '0;
      rstep_r   <= 8'd1;
    end else if (en) begin
      v1_r <= in_accept;
      if (v1_r) begin
        elapsed_r <= elapsed_nxt;
        cur_r     <= cur_nxt;
        goal_r    <= goal_nxt;
        rstep_r   <= rstep_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op1_r  <= in_op;
      tgt1_r <= in_target;
      stp1_r <= in_step;
      raw1_r <= in_raw;
    end
  end

  assign item_valid     = v1_r & emit;
  assign item.raw_sel   = (op1_r == OP_RAW);
  assign item.raw_pulse = raw1_r;
  assign item.angle     = cur_nxt;
  assign item.span      = (cfg.max_pulse >= cfg.min_pulse) ?
                          cfg.max_pulse - cfg.min_pulse : 16'd0;

endmodule

// ===== rtl/ssr_pulse.sv =====
module ssr_pulse import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  item_t       item,
  input  logic        item_valid,
  input  logic [15:0] min_pulse,
  output logic        out_valid,
  output logic [15:0] out_compare,
  output logic [7:0]  out_angle
);

  // stage 2: registered item
  logic        v2_r;
  item_t       it2_r;
  // stage 3: span * angle
  logic        v3_r;
  logic [23:0] prod3_r;
  logic        raw3_r;
  logic [15:0] rawp3_r;
  logic [7:0]  ang3_r;
  // stage 4: reciprocal estimate of the quotient
  logic        v4_r;
  logic [21:0] y4_r;
  logic [15:0] q4_r;
  logic        raw4_r;
  logic [15:0] rawp4_r;
  logic [7:0]  ang4_r;
  // result register
  logic        vo_r;
  logic [15:0] cmp_r;
  logic [7:0]  ango_r;

  logic [23:0] prod_nxt;
  logic [21:0] y3;
  logic [44:0] est_full;
  logic [15:0] q_est;
  logic [22:0] q_times;
  logic [22:0] rem;
  logic [15:0] q_fix;
  logic [15:0] cmp_nxt;

  assign prod_nxt = 24'(it2_r.span) * 24'(it2_r.angle);
  assign y3       = prod3_r[23:2];
  assign est_full = 45'(y3) * 45'(DIV_RECIP);
  assign q_est    = est_full[DIV_SHIFT +: 16];
  // q*45 as shifts and adds
  assign q_times  = (23'(q4_r) << 5) + (23'(q4_r) << 3) + (23'(q4_r) << 2) + 23'(q4_r);
  assign rem      = 23'(y4_r) - q_times;
  assign q_fix    = (rem >= DIV_BY) ? q4_r + 16'd1 : q4_r;
  assign cmp_nxt  = raw4_r ? rawp4_r : min_pulse + q_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v2_r <= item_valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r   <= item;
      prod3_r <= prod_nxt;
      raw3_r  <= it2_r.raw_sel;
      rawp3_r <= it2_r.raw_pulse;
      ang3_r  <= it2_r.angle;
      y4_r    <= y3;
      q4_r    <= q_est;
      raw4_r  <= raw3_r;
      rawp4_r <= rawp3_r;
      ang4_r  <= ang3_r;
      cmp_r   <= cmp_nxt;
      ango_r  <= ang4_r;
    end
  end

  assign out_valid   = vo_r;
  assign out_compare = cmp_r;
  assign out_angle   = ango_r;

endmodule

// ===== rtl/servo_slew_ramp_core.sv =====
// Servo PWM compare generator with a slew-limited angle ramp. Each input word
// is one operation (tuser): tick, move_to, set_angle or write_raw. A tick that
// completes step_interval ticks moves the current angle toward the goal by the
// step size (stopping at the goal) and emits compare = min + span*angle/180;
// set_angle and write_raw emit at once, move_to and short ticks emit nothing.
// Accepts one word per clock while the output register is not held. A word
// passes the input register and ramp update, a registered item, then a
// 16x8 span multiply, a reciprocal multiply for /180, and a remainder fix-up
// with the min_pulse add, before it lands in the output register. in_tready
// drops only while a result sits unread in the output register. Write
// configuration only with the block drained.
module servo_slew_ramp_core import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] target_angle, [15:8] step_size, [31:16] raw_pulse
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] compare_value, [23:16] angle_now
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  item_t item;
  logic  item_valid;
  logic  en;
  logic  in_accept;
  logic [15:0] compare_value;
  logic [7:0]  angle_now;

  // whole pipeline stalls only when the result register is held
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_accept = in_tvalid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse     <= MIN_PULSE_RST;
      cfg_r.max_pulse     <= MAX_PULSE_RST;
      cfg_r.step_interval <= STEP_INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_PULSE:     cfg_r.min_pulse     <= cfg_data;
        REG_MAX_PULSE:     cfg_r.max_pulse     <= cfg_data;
        REG_STEP_INTERVAL: cfg_r.step_interval <= cfg_data;
        default: begin
          // unmapped index: dropped
        end
      endcase
    end
  end

  ssr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_accept  (in_accept),
    .in_op      (in_tuser),
    .in_target  (in_tdata[7:0]),
    .in_step    (in_tdata[15:8]),
    .in_raw     (in_tdata[31:16]),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid)
  );

  ssr_pulse u_pulse (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .item        (item),
    .item_valid  (item_valid),
    .min_pulse   (cfg_r.min_pulse),
    .out_valid   (out_tvalid),
    .out_compare (compare_value),
    .out_angle   (angle_now)
  );

  assign out_tdata = {angle_now, compare_value};

endmodule

// ===== rtl/ssr_checker.sv =====
module ssr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // input side only stalls behind an unread result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // reported angle never leaves the servo range
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:16] <= 8'd180)
    else $error("angle_now above 180");

  // config port never stalls
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind servo_slew_ramp_core ssr_checker u_ssr_checker (.*);

// ===== sim/servo_pulse_checker.sv =====
module servo_pulse_checker import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] target_angle, [15:8] step_size, [31:16] raw_pulse
  input  logic [1:0]  in_tuser,   // [1:0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [15:0] compare_value, [23:16] angle_now
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0]  angle_now;
    logic [15:0] compare_value;
  } servo_word_t;

  logic [15:0] min_pw, max_pw, tick_period;
  logic [15:0] tick_count;
  logic [7:0]  angle, goal, slew;
  servo_word_t pending_words[$];

  function automatic logic [7:0] clamp_deg(input logic [7:0] a);
    return (a > ANGLE_FULL) ? ANGLE_FULL : a;
  endfunction

  function automatic logic [15:0] pulse_at(input logic [7:0] a);
    logic [31:0] span;
    span = (max_pw >= min_pw) ? 32'(max_pw - min_pw) : 32'd0;
    return 16'(32'(min_pw) + (span * 32'(a)) / 32'(ANGLE_FULL));
  endfunction

  // update the servo state for one accepted word, queue its result if any
  task automatic apply_word(input logic [1:0] op, input logic [31:0] d);
    logic [8:0]  sum;
    logic [15:0] pulse;
    logic        emits;
    emits = 1'b0;
    pulse = '0;
    case (op)
      OP_MOVE: begin
        goal = clamp_deg(d[7:0]);
        slew = d[15:8];
      end
      OP_SET: begin
        angle = clamp_deg(d[7:0]);
        goal  = angle;
        pulse = pulse_at(angle);
        emits = 1'b1;
      end
      OP_RAW: begin
        pulse = d[31:16];
        emits = 1'b1;
      end
      OP_TICK: begin
        if (tick_count != TICK_SAT) tick_count = tick_count + 16'd1;
        if (tick_count >= tick_period) begin
          tick_count = '0;
          if (angle < goal) begin
            sum   = {1'b0, angle} + {1'b0, slew};
            angle = (sum > {1'b0, goal}) ? goal : sum[7:0];
          end else if (angle > goal) begin
            angle = ((angle - goal) <= slew) ? goal : angle - slew;
          end
          pulse = pulse_at(angle);
          emits = 1'b1;
        end
      end
    endcase
    if (emits) pending_words.push_back('{angle_now: angle, compare_value: pulse});
  endtask

  always @(posedge clk) begin
    servo_word_t got, want;
    if (!rst_n) begin
      min_pw      = MIN_PULSE_RST;
      max_pw      = MAX_PULSE_RST;
      tick_period = STEP_INTERVAL_RST;
      tick_count  = '0;
      angle       = '0;
      goal        = '0;
      slew        = 8'd1;
      mismatches  = 0;
      pending_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_PULSE:     min_pw      = cfg_data;
          REG_MAX_PULSE:     max_pw      = cfg_data;
          REG_STEP_INTERVAL: tick_period = cfg_data;
          default: ;
        endcase
      end
      // results leave before this edge's input is predicted
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_words.size() == 0) begin
          $display("%0t unexpected result: compare_value %0d angle_now %0d",
                   $time, got.compare_value, got.angle_now);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (got.compare_value !== want.compare_value) begin
            $display("%0t compare_value mismatch: expected %0d, got %0d",
                     $time, want.compare_value, got.compare_value);
            mismatches++;
          end
          if (got.angle_now !== want.angle_now) begin
            $display("%0t angle_now mismatch: expected %0d, got %0d",
                     $time, want.angle_now, got.angle_now);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) apply_word(in_tuser, in_tdata);
    end
    outstanding = pending_words.size();
  end

endmodule

// ===== sim/servo_slew_ramp_core_test.sv =====
module servo_slew_ramp_core_test;
  import ssr_pkg::*;

  // watchdog limit for the whole run, including full stall bursts
  localparam int CYCLE_LIMIT  = 600000;
  // extra drain time after the last result, for words that emit nothing
  localparam int SETTLE       = 12;
  localparam int PHASES       = 8;
  localparam int WORDS_PER_PH = 180;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;       // [7:0] target_angle, [15:8] step_size, [31:16] raw_pulse
  logic [1:0]  in_tuser   = OP_TICK;  // [1:0] operation
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_index  = REG_MIN_PULSE;
  logic [15:0] cfg_data   = '0;
  logic        in_tready, out_tvalid, cfg_ready;
  logic [23:0] out_tdata;             // [15:0] compare_value, [23:16] angle_now

  int mismatches, outstanding;
  int cycles = 0;
  bit quiet  = 1'b0;  // set: neither side idles

  servo_slew_ramp_core uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  servo_pulse_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall bursts between ready stretches
  initial begin
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // Drive one word at a falling edge, hold it until taken. Returns at a
  // falling edge with in_tvalid still high, so back-to-back words drop valid
  // in between only for the random idle gap taken when quiet is clear.
  task automatic send_word(input logic [1:0] op, input logic [7:0] tgt,
                           input logic [7:0] stp, input logic [15:0] raw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {raw, stp, tgt};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  // stop sending, wait for every expected word, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; configure drops it
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
                           input logic [15:0] period);
    write_reg(REG_MIN_PULSE, lo);
    write_reg(REG_MAX_PULSE, hi);
    write_reg(REG_STEP_INTERVAL, period);
    cfg_valid <= 1'b0;
  endtask

  // mostly in-range angles and small slews so ramps actually play out;
  // ticks dominate so steps fire often at short intervals
  task automatic random_word();
    logic [1:0]  op;
    logic [7:0]  tgt, stp;
    logic [15:0] raw;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      op = OP_TICK;
    else if (pick < 70) op = OP_MOVE;
    else if (pick < 82) op = OP_SET;
    else                op = OP_RAW;
    tgt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
    stp = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
    raw = 16'($urandom);
    send_word(op, tgt, stp, raw);
  endtask

  initial begin
    logic [15:0] lo, hi, period;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset settings (500..2500, step every 5 ticks)
    send_word(OP_SET, 8'd0,   8'd0,   16'h0000);
    send_word(OP_SET, 8'd180, 8'd0,   16'h0000);
    send_word(OP_SET, 8'd255, 8'hFF,  16'hFFFF);  // clamps to 180
    send_word(OP_SET, 8'd181, 8'd0,   16'h0000);  // just over full scale
    send_word(OP_RAW, 8'd0,   8'd0,   16'h0000);
    send_word(OP_RAW, 8'hFF,  8'hFF,  16'hFFFF);  // angle_now untouched
    send_word(OP_SET, 8'd90,  8'd0,   16'h0000);
    // downward overshoot: step 255 from 90 lands on 0
    send_word(OP_MOVE, 8'd0,  8'd255, 16'h0000);
    repeat (5) send_word(OP_TICK, 8'd0, 8'd0, 16'h0000);
    // zero slew still emits on the step tick
    send_word(OP_MOVE, 8'd200, 8'd0,  16'h0000);
    repeat (5) send_word(OP_TICK, 8'd0, 8'd0, 16'h0000);
    // upward overshoot with a clamped goal, then a step already at goal
    send_word(OP_MOVE, 8'd250, 8'd200, 16'h0000);
    repeat (10) send_word(OP_TICK, 8'hFF, 8'hFF, 16'hFFFF);
    settle();

    // long interval: the step fires only on the 200th tick
    quiet = 1'b1;
    configure(16'hFFFF, 16'hFFFF, 16'd200);
    send_word(OP_MOVE, 8'd10, 8'd3, 16'h0000);
    repeat (201) send_word(OP_TICK, 8'd0, 8'd0, 16'h0000);
    quiet = 1'b0;
    settle();

    // random phases; first two pin the extremes, the third is fixed, the last runs flat out
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin lo = 16'h0000; hi = 16'hFFFF; period = 16'd0; end
        1:       begin lo = 16'hFFFF; hi = 16'h0000; period = 16'd1; end  // max below min
        2:       begin lo = 16'd1000; hi = 16'd2000; period = 16'd3; end
        default: begin
          lo     = 16'($urandom);
          hi     = 16'($urandom);
          period = 16'($urandom_range(0, 6));
        end
      endcase
      configure(lo, hi, period);
      quiet = (ph == PHASES - 1);
      repeat (WORDS_PER_PH) random_word();
      settle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== servo_slew_ramp_core.f =====
rtl/ssr_pkg.sv
rtl/ssr_ctrl.sv
rtl/ssr_pulse.sv
rtl/servo_slew_ramp_core.sv
rtl/ssr_checker.sv
sim/servo_pulse_checker.sv
sim/servo_slew_ramp_core_test.sv
